// ===== design/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression true at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ple_pkg.sv =====
`default_nettype none

package ple_pkg;

   localparam int VALUE_WIDTH     = 32;
   localparam int POS_WIDTH       = 9;
   localparam int COUNT_WIDTH     = 9;
   localparam int OP_WIDTH        = 3;
   localparam int STATUS_WIDTH    = 3;
   localparam int REQ_TDATA_WIDTH = 48;
   localparam int RSP_TDATA_WIDTH = 48;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_POS   = 3'd1,
      OP_INS_BACK  = 3'd2,
      OP_REM_FRONT = 3'd3,
      OP_REM_POS   = 3'd4,
      OP_REM_BACK  = 3'd5,
      OP_SEARCH    = 3'd6
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_FULL      = 3'd2,
      ST_BAD_POS   = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT_UP,
      S_PLACE,
      S_SHIFT_DOWN,
      S_SCAN,
      S_EMIT
   } state_type;

endpackage

`default_nettype wire

// ===== design/positional_list_engine.sv =====
`default_nettype none

// Ordered list of signed 32-bit values held in a single-port-write, one-read
// synchronous RAM of CAPACITY entries, with a running count. Each request word
// carries an op in req_tuser (insert front / at position / back, remove front /
// at position / back, search) and gives exactly one response word: status,
// removed value (zero unless a remove succeeded) and the count afterwards.
// Requests are handled one at a time. An insert first moves each entry from the
// tail down to its index one place up, then writes the value; a remove reads the
// entry taken out, then closes the gap; a search stops at the first match. Each
// shift step moves one entry, one read and one write per cycle, and a search
// compares one entry per cycle. A finished response sits in an output register,
// so the next request is taken while the previous response waits. No clearing
// pass after reset: only entries below the count are ever read.
module positional_list_engine
   import ple_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // [31:0] value, [40:32] position, [47:41] zero
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   // [2:0] op
   input  logic [OP_WIDTH-1:0]        req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // [2:0] status, [34:3] removed_value, [43:35] count, [47:44] zero
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata
);

`include "assert_macros.svh"

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // RAM address
   localparam int CW = $clog2(CAPACITY + 1);                   // count
   localparam int PW = ((CW > POS_WIDTH) ? CW : POS_WIDTH) + 1; // compare width

   // list store, entry 1 of the list at address 0
   logic [VALUE_WIDTH-1:0] entries_ff [CAPACITY];
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   state_type              state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [AW-1:0]          ptr_ff, ptr_in;     // address whose data lands next
   logic [AW-1:0]          lo_ff, lo_in;       // target index of the op
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   status_type             status_ff, status_in;
   logic [VALUE_WIDTH-1:0] removed_ff, removed_in;
   logic                   first_ff, first_in; // first read of a remove
   logic                   rsp_valid_ff;
   logic [RSP_TDATA_WIDTH-1:0] rsp_data_ff;

   // RAM ports
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;
   logic [AW-1:0]          rd_addr;

   // request decode
   op_type                 req_op;
   logic [VALUE_WIDTH-1:0] req_value;
   logic [POS_WIDTH-1:0]   req_pos;
   logic [PW-1:0]          pos_ext;
   logic [PW-1:0]          cnt_ext;
   logic [AW-1:0]          last_idx;
   logic                   is_full;
   logic                   is_empty;
   state_type              dec_state;
   status_type             dec_status;
   logic [AW-1:0]          dec_idx;
   logic [AW-1:0]          dec_start;

   logic                   req_accept;
   logic                   slot_free;
   logic                   rsp_load;
   logic                   at_lo;
   logic                   at_last;
   logic                   scan_hit;

   assign req_op    = op_type'(req_tuser);
   assign req_value = req_tdata[VALUE_WIDTH-1:0];
   assign req_pos   = req_tdata[VALUE_WIDTH +: POS_WIDTH];

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_load   = (state_ff == S_EMIT) && slot_free;

   assign pos_ext  = PW'(req_pos);
   assign cnt_ext  = PW'(count_ff);
   assign last_idx = AW'(count_ff - CW'(1));
   assign is_full  = (count_ff == CW'(CAPACITY));
   assign is_empty = (count_ff == '0);

   assign at_lo    = (ptr_ff == lo_ff);
   assign at_last  = (ptr_ff == last_idx);
   assign scan_hit = (rd_data_ff == value_ff);

   // what a request does, judged against the current count
   always_comb begin
      dec_state  = S_EMIT;
      dec_status = ST_OK;
      dec_idx    = '0;
      unique case (req_op) inside
         OP_INS_FRONT, OP_INS_POS, OP_INS_BACK: begin
            if (req_op == OP_INS_POS &&
                (req_pos == '0 || pos_ext > cnt_ext + PW'(1))) begin
               dec_status = ST_BAD_POS;
            end else if (is_full) begin
               dec_status = ST_FULL;
            end else begin
               if (req_op == OP_INS_POS) begin
                  dec_idx = AW'(pos_ext - PW'(1));
               end else if (req_op == OP_INS_BACK) begin
                  dec_idx = AW'(count_ff);
               end
               // appending needs no shift
               dec_state = (CW'(dec_idx) == count_ff) ? S_PLACE : S_SHIFT_UP;
            end
         end
         OP_REM_FRONT, OP_REM_POS, OP_REM_BACK: begin
            if (is_empty) begin
               dec_status = ST_EMPTY;
            end else if (req_op == OP_REM_POS &&
                         (req_pos == '0 || pos_ext > cnt_ext)) begin
               dec_status = ST_BAD_POS;
            end else begin
               if (req_op == OP_REM_POS) begin
                  dec_idx = AW'(pos_ext - PW'(1));
               end else if (req_op == OP_REM_BACK) begin
                  dec_idx = last_idx;
               end
               dec_state = S_SHIFT_DOWN;
            end
         end
         OP_SEARCH: begin
            if (is_empty) begin
               dec_status = ST_NOT_FOUND;
            end else begin
               dec_state = S_SCAN;
            end
         end
         default: begin
            // unused op: no change, plain OK
         end
      endcase
   end

   // inserts shift from the tail downwards, everything else reads from idx up
   assign dec_start = (dec_state == S_SHIFT_UP) ? last_idx : dec_idx;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = dec_state;
            end
         end
         S_SHIFT_UP: begin
            if (at_lo) begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            state_in = S_EMIT;
         end
         S_SHIFT_DOWN: begin
            if (at_last) begin
               state_in = S_EMIT;
            end
         end
         S_SCAN: begin
            if (scan_hit || at_last) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath and RAM control
   always_comb begin
      count_in   = count_ff;
      ptr_in     = ptr_ff;
      lo_in      = lo_ff;
      value_in   = value_ff;
      status_in  = status_ff;
      removed_in = removed_ff;
      first_in   = first_ff;
      wr_en      = 1'b0;
      wr_addr    = ptr_ff;
      wr_data    = rd_data_ff;
      rd_addr    = ptr_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               value_in   = req_value;
               lo_in      = dec_idx;
               ptr_in     = dec_start;
               rd_addr    = dec_start;
               status_in  = dec_status;
               removed_in = '0;
               first_in   = 1'b1;
            end
         end
         S_SHIFT_UP: begin
            // entry at ptr moves one place towards the tail
            wr_en   = 1'b1;
            wr_addr = ptr_ff + AW'(1);
            if (!at_lo) begin
               ptr_in  = ptr_ff - AW'(1);
               rd_addr = ptr_ff - AW'(1);
            end
         end
         S_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = lo_ff;
            wr_data  = value_ff;
            count_in = count_ff + CW'(1);
         end
         S_SHIFT_DOWN: begin
            // first word read is the one taken out, later ones close the gap
            first_in = 1'b0;
            if (first_ff) begin
               removed_in = rd_data_ff;
            end else begin
               wr_en   = 1'b1;
               wr_addr = ptr_ff - AW'(1);
            end
            if (at_last) begin
               count_in = count_ff - CW'(1);
            end else begin
               ptr_in  = ptr_ff + AW'(1);
               rd_addr = ptr_ff + AW'(1);
            end
         end
         S_SCAN: begin
            if (scan_hit) begin
               status_in = ST_OK;
            end else if (at_last) begin
               status_in = ST_NOT_FOUND;
            end else begin
               ptr_in  = ptr_ff + AW'(1);
               rd_addr = ptr_ff + AW'(1);
            end
         end
         S_EMIT: begin
            // response register loads here when free
         end
         default: begin
         end
      endcase
   end

   // list RAM, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entries_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      lo_ff      <= lo_in;
      value_ff   <= value_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
      first_ff   <= first_in;
   end

   // response word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {
            (RSP_TDATA_WIDTH - COUNT_WIDTH - VALUE_WIDTH - STATUS_WIDTH)'(0),
            COUNT_WIDTH'(count_ff),
            removed_ff,
            status_ff
         };
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_HOLDS(a_count_bound, clock, reset, count_ff <= CW'(CAPACITY), "count above capacity")
   `ASSERT_NEXT(a_count_moves_on_finish, clock, reset, state_ff != S_PLACE && state_ff != S_SHIFT_DOWN, $stable(count_ff), "count changed outside place or close-up step")
   `ASSERT_HOLDS(a_shift_no_overlap, clock, reset, !(wr_en && (state_ff == S_SHIFT_UP || state_ff == S_SHIFT_DOWN)) || (wr_addr != rd_addr), "shift reads and writes same entry")
   `ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_tvalid && req_tready, state_ff != S_IDLE, "accepted word left no work")

endmodule

`default_nettype wire

// ===== tb/sv/positional_list_engine_tb.sv =====
`timescale 1ns / 1ps

module positional_list_engine_tb
   import ple_pkg::*;
();

   localparam int          LIST_CAPACITY = 256;
   localparam int          GAP_PERCENT   = 34;
   // op code outside the package enum; the block must leave the list alone
   localparam logic [2:0]  OP_UNUSED     = 3'd7;

   // expected response word, one per accepted request
   typedef struct {
      status_type  status;
      logic [31:0] removed;
      logic [8:0]  count;
   } list_result_type;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   // [31:0] value, [40:32] position, [47:41] zero
   logic [REQ_TDATA_WIDTH-1:0] req_tdata  = '0;
   // [2:0] op
   logic [OP_WIDTH-1:0]        req_tuser  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   // [2:0] status, [34:3] removed_value, [43:35] count, [47:44] zero
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;

   // shadow copy of the list, entry 1 at index 0
   logic [31:0]      shadow_list [LIST_CAPACITY];
   int               shadow_len = 0;
   list_result_type  pending_results [$];
   int               error_count = 0;
   bit               sender_gaps = 1'b1;
   bit               sink_stalls = 1'b1;

   positional_list_engine #(
      .CAPACITY(LIST_CAPACITY)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #6 clock = ~clock;

   // generous ceiling: every request at full shift length plus stalls, several times over
   initial begin
      #40_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------- prediction

   function automatic void shadow_insert(int idx, logic [31:0] value);
      for (int i = shadow_len; i > idx; i--)
         shadow_list[i] = shadow_list[i-1];
      shadow_list[idx] = value;
      shadow_len++;
   endfunction

   function automatic logic [31:0] shadow_remove(int idx);
      logic [31:0] taken;
      taken = shadow_list[idx];
      for (int i = idx; i + 1 < shadow_len; i++)
         shadow_list[i] = shadow_list[i+1];
      shadow_len--;
      return taken;
   endfunction

   function automatic list_result_type predict_list_op(logic [2:0] op, logic [31:0] value,
                                                       logic [8:0] pos);
      list_result_type r;
      int              p;
      p         = pos;
      r.status  = ST_OK;
      r.removed = '0;
      case (op)
         OP_INS_FRONT: begin
            if (shadow_len >= LIST_CAPACITY) r.status = ST_FULL;
            else shadow_insert(0, value);
         end
         OP_INS_POS: begin
            // bad position wins over full
            if (p < 1 || p > shadow_len + 1) r.status = ST_BAD_POS;
            else if (shadow_len >= LIST_CAPACITY) r.status = ST_FULL;
            else shadow_insert(p - 1, value);
         end
         OP_INS_BACK: begin
            if (shadow_len >= LIST_CAPACITY) r.status = ST_FULL;
            else shadow_insert(shadow_len, value);
         end
         OP_REM_FRONT: begin
            if (shadow_len == 0) r.status = ST_EMPTY;
            else r.removed = shadow_remove(0);
         end
         OP_REM_POS: begin
            // empty wins over bad position
            if (shadow_len == 0) r.status = ST_EMPTY;
            else if (p < 1 || p > shadow_len) r.status = ST_BAD_POS;
            else r.removed = shadow_remove(p - 1);
         end
         OP_REM_BACK: begin
            if (shadow_len == 0) r.status = ST_EMPTY;
            else r.removed = shadow_remove(shadow_len - 1);
         end
         OP_SEARCH: begin
            r.status = ST_NOT_FOUND;
            for (int i = 0; i < shadow_len; i++) begin
               if (shadow_list[i] == value) begin
                  r.status = ST_OK;
                  break;
               end
            end
         end
         default: ;
      endcase
      r.count = shadow_len[8:0];
      return r;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin : check_responses
      list_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unrequested response", 32'd1, 32'd0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[2:0] !== want.status)
               report_mismatch("status", 32'(rsp_tdata[2:0]), 32'(want.status));
            if (rsp_tdata[34:3] !== want.removed)
               report_mismatch("removed_value", rsp_tdata[34:3], want.removed);
            if (rsp_tdata[43:35] !== want.count)
               report_mismatch("count", 32'(rsp_tdata[43:35]), 32'(want.count));
         end
      end
   end

   // sink back-pressure, one update per falling edge
   always @(negedge clock)
      rsp_tready <= !sink_stalls || ($urandom_range(0, 99) >= GAP_PERCENT);

   // ---------------------------------------------------------------- stimulus

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(input logic [2:0] op, input logic [31:0] value,
                            input logic [8:0] pos);
      while (sender_gaps && $urandom_range(0, 99) < GAP_PERCENT) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {7'd0, pos, value};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_list_op(op, value, pos));
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   function automatic logic [2:0] choose_op(int insert_pct, int search_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < insert_pct) return 3'($urandom_range(OP_INS_FRONT, OP_INS_BACK));
      if (r < insert_pct + search_pct) return OP_SEARCH;
      return 3'($urandom_range(OP_REM_FRONT, OP_REM_BACK));
   endfunction

   // mostly well-formed positions, with a share of out-of-range ones
   task automatic send_random(input logic [2:0] op);
      logic [31:0] value;
      int          pos;
      value = ($urandom_range(0, 9) < 7) ? $urandom : 32'($urandom_range(0, 7) - 4);
      pos   = $urandom_range(0, 511);
      if (op == OP_SEARCH && shadow_len > 0 && $urandom_range(0, 1))
         value = shadow_list[$urandom_range(0, shadow_len - 1)];
      if ($urandom_range(0, 99) < 85) begin
         if (op == OP_INS_POS)
            pos = $urandom_range(1, shadow_len + 1);
         else if (op == OP_REM_POS && shadow_len > 0)
            pos = $urandom_range(1, shadow_len);
      end else if ($urandom_range(0, 1)) begin
         pos = (op == OP_INS_POS) ? shadow_len + 2 : shadow_len + 1;
      end
      send_word(op, value, pos[8:0]);
   endtask

   // empty-list rejections, value extremes, every op, position limits
   task automatic test_directed_ops();
      send_word(OP_REM_FRONT, 32'd0, 9'd0);
      send_word(OP_REM_BACK,  32'd0, 9'd0);
      send_word(OP_REM_POS,   32'd0, 9'd0);         // empty beats bad position
      send_word(OP_SEARCH,    32'd0, 9'd0);         // search on empty list
      send_word(OP_INS_POS,   32'd7, 9'd0);
      send_word(OP_INS_POS,   32'd7, 9'd2);
      send_word(OP_UNUSED,    32'hFFFF_FFFF, 9'd511);
      send_word(OP_INS_POS,   32'h8000_0000, 9'd1);
      send_word(OP_INS_FRONT, 32'h7FFF_FFFF, 9'd0);
      send_word(OP_INS_BACK,  32'hFFFF_FFFF, 9'd511);
      send_word(OP_INS_BACK,  32'h0000_0000, 9'd0);
      send_word(OP_INS_POS,   32'h5555_5555, 9'd5);  // one past the end
      send_word(OP_INS_POS,   32'hAAAA_AAAA, 9'd3);
      send_word(OP_SEARCH,    32'h8000_0000, 9'd0);
      send_word(OP_SEARCH,    32'h1234_5678, 9'd0);
      send_word(OP_REM_POS,   32'd0, 9'd0);
      send_word(OP_REM_POS,   32'd0, 9'd7);
      send_word(OP_REM_POS,   32'd0, 9'd511);
      send_word(OP_REM_POS,   32'd0, 9'd6);
      send_word(OP_REM_POS,   32'd0, 9'd1);
      send_word(OP_REM_POS,   32'd0, 9'd2);
      send_word(OP_REM_BACK,  32'd0, 9'd0);
      send_word(OP_REM_FRONT, 32'd0, 9'd0);
      send_word(OP_SEARCH,    32'h5555_5555, 9'd0);
   endtask

   // list length wanders around a moving target, mostly short
   task automatic test_random_mix(input int words);
      int list_target;
      list_target = 0;
      for (int n = 0; n < words; n++) begin
         if (n % 100 == 0)
            list_target = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 200)
                                                      : $urandom_range(0, 40);
         // a long stretch at full rate on both sides
         if (n == 300) begin
            sender_gaps = 1'b0;
            sink_stalls = 1'b0;
         end
         if (n == 500) begin
            sender_gaps = 1'b1;
            sink_stalls = 1'b1;
         end
         if (shadow_len < list_target) send_random(choose_op(60, 10));
         else send_random(choose_op(30, 15));
      end
   endtask

   // grow to capacity, probe the full list, then drain to empty
   task automatic test_full_and_drain();
      wait_for_results();
      while (shadow_len < LIST_CAPACITY) send_random(choose_op(90, 10));
      send_word(OP_INS_FRONT, 32'd1, 9'd0);
      send_word(OP_INS_BACK,  32'd1, 9'd0);
      send_word(OP_INS_POS,   32'd1, 9'd1);
      send_word(OP_INS_POS,   32'd1, 9'd257);        // valid position, but full
      send_word(OP_INS_POS,   32'd1, 9'd258);        // bad position beats full
      send_word(OP_INS_POS,   32'd1, 9'd0);
      send_word(OP_INS_POS,   32'd1, 9'd511);
      send_word(OP_SEARCH,    shadow_list[LIST_CAPACITY-1], 9'd0);
      send_word(OP_REM_POS,   32'd0, 9'd256);
      send_word(OP_INS_POS,   32'hDEAD_BEEF, 9'd256);
      send_word(OP_REM_POS,   32'd0, 9'd257);
      while (shadow_len > 0) send_random(choose_op(0, 10));
      send_word(OP_REM_BACK,  32'd0, 9'd0);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      test_directed_ops();
      test_random_mix(1050);
      test_full_and_drain();
      wait_for_results();
      repeat (LIST_CAPACITY + 50) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
